// ----- src/tlba_pkg.sv -----
// Package for the two-level bitmap allocator: sizes, function codes, sequencer states,
// the zero-scan status record and the chunk priority helper. No dependencies.
package tlba_pkg;

   localparam int WORD_COUNT   = 64;
   localparam int WORD_BITS    = 64;
   localparam int WADDR_W      = $clog2(WORD_COUNT);
   localparam int BITPOS_W     = $clog2(WORD_BITS);
   localparam int INDEX_W      = 12;
   localparam int COUNT_W      = 13;
   localparam int FUNC_W       = 3;
   localparam int CHUNK_BITS   = 8;
   localparam int CHUNK_COUNT  = WORD_BITS / CHUNK_BITS;
   localparam int CHUNK_W      = $clog2(CHUNK_COUNT);
   localparam int CHUNK_POS_W  = $clog2(CHUNK_BITS);

   localparam logic [COUNT_W-1:0] CAPACITY        = COUNT_W'(WORD_COUNT * WORD_BITS);
   localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = COUNT_W'(4096);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET       = 3'd0,
      FUNC_CLEAR     = 3'd1,
      FUNC_READ      = 3'd2,
      FUNC_FIND      = 3'd3,
      FUNC_FIND_SET  = 3'd4,
      FUNC_CLEAR_ALL = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_SUM,
      ST_READ,
      ST_EXEC,
      ST_SCAN_WORD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                done;
      logic                hit;
      logic [BITPOS_W-1:0] position;
   } scan_status_type;

   // Position of the lowest zero bit in one chunk; zero when the chunk is all ones.
   function automatic logic [CHUNK_POS_W-1:0] chunk_lowest_zero(
      input logic [CHUNK_BITS-1:0] chunk
   );
      logic [CHUNK_POS_W-1:0] pos;
      pos = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         if (!chunk[i]) begin
            pos = CHUNK_POS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- src/tlba_channels.sv -----
// Request and response channel interfaces of the two-level bitmap allocator.
// Depends on tlba_pkg for the field widths.
interface tlba_req_if;
   import tlba_pkg::*;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [INDEX_W-1:0]  bit_index;
   modport source (output valid, func, bit_index, input ready);
   modport sink (input valid, func, bit_index, output ready);
endinterface

interface tlba_rsp_if;
   import tlba_pkg::*;
   logic                valid;
   logic                ready;
   logic                bit_value;
   logic                found;
   logic [INDEX_W-1:0]  found_index;
   logic                range_error;
   modport source (output valid, bit_value, found, found_index, range_error, input ready);
   modport sink (input valid, bit_value, found, found_index, range_error, output ready);
endinterface

// ----- src/two_level_bitmap_allocator_unit.sv -----
// Top level of the two-level bitmap allocator: sequencer, map memory, summary word.
// Depends on tlba_pkg, tlba_channels and tlba_zero_scan.
//
// A request carries a function code and an entry index and yields exactly one response.
// Set, clear and read check the index against the bit count and, when it is in range,
// read the map word; set and clear then write it back. The two find functions run the
// shared zero-scan unit first over the summary word and then, when that scan finds a
// word that is not full, over the chosen map word, one 8-bit chunk per cycle.
// Clear-all drops the per-word valid bits and the summary word at once.
// Only one request is in flight; the request side is ready again in the same cycle
// as the response appears in the output register, and the next request can start
// while the receiver still holds off.
// If the receiver stalls long enough, the finished result waits inside the block.
// Reset clears all valid bits and the summary word, so the map reads as cleared right
// away, and sets the bit count to 4096.
// The user must write the bit count through the csr port only while no request is in
// flight; the block does not enforce it.
module two_level_bitmap_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   tlba_req_if.sink                      req_channel,
   tlba_rsp_if.source                    rsp_channel,
   input  logic                          csr_write_enable,
   input  logic [tlba_pkg::COUNT_W-1:0]  csr_write_data
);
   import tlba_pkg::*;

   state_type                 state_ff, state_in;
   logic [FUNC_W-1:0]         func_ff;
   logic [INDEX_W-1:0]        index_ff;
   logic [COUNT_W-1:0]        bit_count_ff;
   word_type                  summary_ff;
   logic [WORD_COUNT-1:0]     valid_ff;
   word_type                  mem [WORD_COUNT];
   word_type                  rdata_ff;
   logic [WADDR_W-1:0]        addr_ff, addr_in;

   logic                      bit_value_ff, found_ff, range_error_ff;
   logic [INDEX_W-1:0]        found_index_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_bit_value_ff, rsp_found_ff, rsp_range_error_ff;
   logic [INDEX_W-1:0]        rsp_found_index_ff;

   logic [COUNT_W-1:0]        limit;
   logic                      index_bad;
   logic                      is_bit_op, is_find;
   word_type                  cur_word, exec_word, find_word;
   logic [INDEX_W-1:0]        find_index;
   logic                      find_ok;
   logic                      word_in_range;
   scan_status_type           scan;

   logic                      scan_start;
   word_type                  scan_operand;
   logic                      addr_load;
   logic                      mem_we;
   word_type                  mem_wdata;
   logic                      clear_all;
   logic                      rsp_load;

   assign limit     = (bit_count_ff > CAPACITY) ? CAPACITY : bit_count_ff;
   assign index_bad = ({1'b0, index_ff} >= limit);
   assign is_bit_op = func_ff inside {FUNC_SET, FUNC_CLEAR, FUNC_READ};
   assign is_find   = func_ff inside {FUNC_FIND, FUNC_FIND_SET};
   assign cur_word  = valid_ff[addr_ff] ? rdata_ff : '0;
   assign exec_word = (func_ff == FUNC_SET)
                      ? (cur_word | (word_type'(1) << index_ff[BITPOS_W-1:0]))
                      : (cur_word & ~(word_type'(1) << index_ff[BITPOS_W-1:0]));
   assign find_word  = cur_word | (word_type'(1) << scan.position);
   assign find_index = INDEX_W'({addr_ff, scan.position});
   assign find_ok    = ({1'b0, find_index} < limit);
   assign word_in_range = ({1'b0, scan.position} < (BITPOS_W + 1)'(WORD_COUNT));

   tlba_zero_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .operand (scan_operand),
      .status  (scan)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_channel.valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (is_bit_op) begin
               state_in = index_bad ? ST_DONE : ST_READ;
            end else if (is_find) begin
               state_in = ST_SCAN_SUM;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_SUM: begin
            if (scan.done) begin
               state_in = (scan.hit && word_in_range) ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = is_find ? ST_SCAN_WORD : ST_DONE;
         end
         ST_SCAN_WORD: begin
            if (scan.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_channel.ready = 1'b0;
      scan_start        = 1'b0;
      scan_operand      = cur_word;
      addr_load         = 1'b0;
      addr_in           = WADDR_W'(index_ff[INDEX_W-1:BITPOS_W]);
      mem_we            = 1'b0;
      mem_wdata         = exec_word;
      clear_all         = 1'b0;
      rsp_load          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_channel.ready = 1'b1;
         end
         ST_DECODE: begin
            scan_start   = is_find;
            scan_operand = summary_ff;
            addr_load    = 1'b1;
            clear_all    = (func_ff == FUNC_CLEAR_ALL);
         end
         ST_SCAN_SUM: begin
            addr_load = scan.done;
            addr_in   = WADDR_W'(scan.position);
         end
         ST_EXEC: begin
            scan_start = is_find;
            mem_we     = (func_ff == FUNC_SET) || (func_ff == FUNC_CLEAR);
         end
         ST_SCAN_WORD: begin
            mem_we    = scan.done && find_ok && (func_ff == FUNC_FIND_SET);
            mem_wdata = find_word;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_channel.ready;
         end
         default: begin
            req_channel.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_count_ff <= BIT_COUNT_RESET;
         summary_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            bit_count_ff <= csr_write_data;
         end
         if (clear_all) begin
            summary_ff <= '0;
            valid_ff   <= '0;
         end else if (mem_we) begin
            valid_ff[addr_ff]   <= 1'b1;
            summary_ff[addr_ff] <= &mem_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (req_channel.valid && req_channel.ready) begin
         func_ff  <= req_channel.func;
         index_ff <= req_channel.bit_index;
      end
      if (addr_load) begin
         addr_ff <= addr_in;
      end
      if (state_ff == ST_DECODE) begin
         bit_value_ff   <= 1'b0;
         found_ff       <= 1'b0;
         found_index_ff <= '0;
         range_error_ff <= is_bit_op && index_bad;
      end
      if (state_ff == ST_EXEC) begin
         bit_value_ff <= (func_ff == FUNC_READ) && cur_word[index_ff[BITPOS_W-1:0]];
      end
      if (state_ff == ST_SCAN_WORD && scan.done) begin
         found_ff       <= find_ok;
         found_index_ff <= find_ok ? find_index : '0;
      end
      if (rsp_load) begin
         rsp_bit_value_ff   <= bit_value_ff;
         rsp_found_ff       <= found_ff;
         rsp_found_index_ff <= found_index_ff;
         rsp_range_error_ff <= range_error_ff;
      end
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.bit_value   = rsp_bit_value_ff;
   assign rsp_channel.found       = rsp_found_ff;
   assign rsp_channel.found_index = rsp_found_index_ff;
   assign rsp_channel.range_error = rsp_range_error_ff;

   // A response never reports both a found entry and an index error.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && rsp_channel.found) |-> !rsp_channel.range_error)
      else $error("response reports found together with range error");

   // A found entry always lies below the active limit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && found_ff) |-> ({1'b0, found_index_ff} < limit))
      else $error("found entry at or above the limit");

   // Clear-all leaves no word marked full and no word holding data.
   assert property (@(posedge clock) disable iff (reset)
      clear_all |=> (summary_ff == '0 && valid_ff == '0))
      else $error("clear-all did not empty the map");

   // A word can only be marked full once it has been written.
   assert property (@(posedge clock) disable iff (reset)
      (summary_ff & ~word_type'(valid_ff)) == '0)
      else $error("summary marks an unwritten word as full");

endmodule

// ----- src/tlba_zero_scan.sv -----
// Shared find-first-zero unit: scans a 64-bit word one 8-bit chunk per cycle.
// Depends on tlba_pkg.
module tlba_zero_scan (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  tlba_pkg::word_type         operand,
   output tlba_pkg::scan_status_type  status
);
   import tlba_pkg::*;

   logic                   busy_ff, busy_in;
   word_type               opnd_ff, opnd_in;
   logic [CHUNK_W-1:0]     chunk_ff, chunk_in;
   logic [CHUNK_BITS-1:0]  chunk;
   logic                   chunk_free;
   logic                   last_chunk;

   assign chunk      = opnd_ff[CHUNK_BITS-1:0];
   assign chunk_free = (chunk != '1);
   assign last_chunk = (chunk_ff == CHUNK_W'(CHUNK_COUNT - 1));

   always_comb begin
      status.done     = busy_ff && (chunk_free || last_chunk);
      status.hit      = busy_ff && chunk_free;
      status.position = chunk_free ? {chunk_ff, chunk_lowest_zero(chunk)} : '1;
   end

   always_comb begin
      busy_in  = busy_ff;
      opnd_in  = opnd_ff;
      chunk_in = chunk_ff;
      if (start) begin
         busy_in  = 1'b1;
         opnd_in  = operand;
         chunk_in = '0;
      end else if (busy_ff) begin
         if (status.done) begin
            busy_in = 1'b0;
         end else begin
            opnd_in  = opnd_ff >> CHUNK_BITS;
            chunk_in = chunk_ff + CHUNK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      opnd_ff  <= opnd_in;
      chunk_ff <= chunk_in;
   end

endmodule
